// ===== design/mpq_pkg.sv =====
// Shared types, widths and codes for the max priority queue.
// No dependencies; every other file of the block imports it.
package mpq_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;
  localparam int CNT_OUT_W     = 7;
  localparam int CAP_W         = 7;
  localparam int DEPTH_DEFAULT = 64;
  localparam int OR_GROUP      = 16;   // match flags folded per first-level OR register
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  typedef logic signed [DATA_W-1:0] value_t;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Register index, taken from the word address bits of paddr
  localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    logic   srch;
    value_t value;
  } cmd_t;

endpackage

// ===== design/mpq_if.sv =====
// Request and response channel interfaces of the max priority queue.
// Depends on mpq_pkg.
interface mpq_req_if;
  import mpq_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  value_t          value_in;

  modport source (output valid, opcode, value_in, input ready);
  modport sink   (input valid, opcode, value_in, output ready);
endinterface

interface mpq_rsp_if;
  import mpq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic                 found;
  value_t               value_out;
  logic [CNT_OUT_W-1:0] count_after;

  modport source (output valid, status, found, value_out, count_after, input ready);
  modport sink   (input valid, status, found, value_out, count_after, output ready);
endinterface

// ===== design/max_priority_queue.sv =====
// Top level of the max priority queue: controller, APB register and cell row.
// Depends on mpq_pkg, mpq_if, mpq_cell and mpq_or_tree.
//
//   channel | dir | beat contents                               | handshake
//   --------+-----+---------------------------------------------+--------------
//   req     | in  | opcode, value_in                            | valid/ready
//   rsp     | out | status, found, value_out, count_after       | valid/ready
//   apb     | in  | capacity_limit at byte address 0            | psel/penable
//
// Operations: insert, remove and the unused opcode complete in IDLE; the result is
//   registered on the accepting edge. Search latches every cell's match flag,
//   passes through the registered OR tree (group and hit registers), then
//   loads the result. The OR tree sets the search latency.
// Reset clears the count, the controller and the capacity register (to 64);
//   cell contents are left as they are and only live cells are ever read.
// A request is taken only when the controller is idle and the result
//   register is empty or being drained in the same cycle.
module max_priority_queue #(
  parameter int DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  mpq_req_if.sink                        req,
  mpq_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpq_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mpq_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [1:0] {IDLE, S_GRP, S_HIT, S_OUT} state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CAP_W-1:0]     capacity;
  logic                 out_valid;
  logic [ST_W-1:0]      out_status;
  logic                 out_found;
  value_t               out_value;
  logic [CNT_OUT_W-1:0] out_count;

  logic                 req_beat;
  logic                 rsp_beat;
  logic                 cfg_write;
  logic                 full;
  logic                 empty;
  logic [CMPW-1:0]      cap_ext;
  logic [CMPW-1:0]      cap_eff;
  cmd_t                 cmd;
  logic                 hit;

  value_t               cell_data  [DEPTH];
  value_t               data_l     [DEPTH];
  value_t               data_r     [DEPTH];
  logic [DEPTH-1:0]     keep;
  logic [DEPTH-1:0]     keep_l;
  logic [DEPTH-1:0]     occ;
  logic [DEPTH-1:0]     match;

  // ---------------------------------------------------------------- APB
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY) ? APB_DATA_W'(capacity) : '0;

  // ---------------------------------------------------------------- handshakes
  assign req.ready = (state == IDLE) && (!out_valid || rsp.ready);
  assign req_beat  = req.valid && req.ready;
  assign rsp_beat  = rsp.valid && rsp.ready;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found       = out_found;
  assign rsp.value_out   = out_value;
  assign rsp.count_after = out_count;

  // ---------------------------------------------------------------- control
  // Effective capacity is the smaller of the register and the built depth.
  assign cap_ext = CMPW'(capacity);
  assign cap_eff = (cap_ext < CMPW'(DEPTH)) ? cap_ext : CMPW'(DEPTH);
  assign full    = CMPW'(count) >= cap_eff;
  assign empty   = (count == '0);

  always_comb begin
    cmd.ins   = req_beat && (req.opcode == OP_INSERT) && !full;
    cmd.rem   = req_beat && (req.opcode == OP_REMOVE) && !empty;
    cmd.srch  = req_beat && (req.opcode == OP_SEARCH);
    cmd.value = req.value_in;
    count_next = count;
    if (cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cmd.rem) begin
      count_next = count - 1'b1;
    end
  end

  // ---------------------------------------------------------------- cell row
  // Cells hold the live entries in descending order from cell 0; a cell is
  // live while its index lies below the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = count > CW'(i);

    if (i == 0) begin : g_first
      assign keep_l[i] = 1'b1;
      assign data_l[i] = '0;
    end else begin : g_inner
      assign keep_l[i] = keep[i-1];
      assign data_l[i] = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign data_r[i] = '0;
    end else begin : g_body
      assign data_r[i] = cell_data[i+1];
    end

    mpq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ[i]),
      .keep_left  (keep_l[i]),
      .data_left  (data_l[i]),
      .data_right (data_r[i]),
      .data       (cell_data[i]),
      .keep       (keep[i]),
      .match      (match[i])
    );
  end

  mpq_or_tree #(.DEPTH(DEPTH)) u_or_tree (
    .clk   (clk),
    .match (match),
    .hit   (hit)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_write && (paddr[APB_ADDR_W-1:2] == REG_CAPACITY)) begin
        capacity <= pwdata[CAP_W-1:0];
      end
      // Drop the result once its beat is taken; a new load below overrides.
      if (rsp_beat) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_beat) begin
            if (req.opcode == OP_SEARCH) begin
              state <= S_GRP;
            end else begin
              out_valid <= 1'b1;
              out_found <= 1'b0;
              out_count <= CNT_OUT_W'(count_next);
              out_value <= cmd.rem ? cell_data[0] : '0;
              if ((req.opcode == OP_INSERT) && full) begin
                out_status <= ST_FULL;
              end else if ((req.opcode == OP_REMOVE) && empty) begin
                out_status <= ST_EMPTY;
              end else begin
                out_status <= ST_DONE;
              end
            end
          end
        end
        S_GRP: state <= S_HIT;
        S_HIT: state <= S_OUT;
        S_OUT: begin
          // Result register is free here: the request was taken only when it was.
          out_valid  <= 1'b1;
          out_status <= ST_DONE;
          out_found  <= hit;
          out_value  <= '0;
          out_count  <= CNT_OUT_W'(count);
          state      <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(count) <= CMPW'(DEPTH))
    else $error("entry count beyond built depth");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (cell_data[0] >= cell_data[1]))
    else $error("head cell not the maximum");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (req_beat && (req.opcode == OP_INSERT) && full) |=> $stable(count))
    else $error("rejected insert changed the count");

  a_search_result: assert property (@(posedge clk) disable iff (rst)
    (req_beat && (req.opcode == OP_SEARCH)) |-> ##4 rsp.valid)
    else $error("search result missing four cycles after request");

endmodule

// ===== design/mpq_cell.sv =====
// One cell of the sorted systolic array: holds one entry, shifts on insert/remove.
// Depends on mpq_pkg.
module mpq_cell (
  input  logic           clk,
  input  mpq_pkg::cmd_t  cmd,
  input  logic           occ,        // this cell holds a live entry
  input  logic           keep_left,  // left neighbour keeps its entry on insert
  input  mpq_pkg::value_t data_left,
  input  mpq_pkg::value_t data_right,
  output mpq_pkg::value_t data,
  output logic           keep,
  output logic           match
);
  import mpq_pkg::*;

  value_t data_next;

  assign keep = occ && (data >= cmd.value);

  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (keep) begin
        data_next = data;
      end else if (keep_left) begin
        data_next = cmd.value;
      end else begin
        data_next = data_left;
      end
    end else if (cmd.rem) begin
      data_next = data_right;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (cmd.srch) begin
      match <= occ && (data == cmd.value);
    end
  end

endmodule

// ===== design/mpq_or_tree.sv =====
// Two-level registered OR over the cell match flags.
// Depends on mpq_pkg.
module mpq_or_tree #(
  parameter int DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic [DEPTH-1:0] match,
  output logic             hit
);
  import mpq_pkg::*;

  localparam int NG = (DEPTH + OR_GROUP - 1) / OR_GROUP;

  logic [NG*OR_GROUP-1:0] padded;
  logic [NG-1:0]          grp;

  assign padded = (NG*OR_GROUP)'(match);

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp[g] <= |padded[g*OR_GROUP +: OR_GROUP];
    end
    hit <= |grp;
  end

endmodule
